/* design/jse_pkg.sv */
// ----------------------------------------------------------------------------
// JSON string escape encoder package
// Character codes and the command word passed from the front to the back.
// ----------------------------------------------------------------------------
package jse_pkg;

	localparam logic [15:0] CH_QUOTE     = 16'h0022;
	localparam logic [15:0] CH_BACKSLASH = 16'h005C;
	localparam logic [15:0] CH_SPACE     = 16'h0020;
	localparam logic [15:0] CH_TILDE     = 16'h007E;
	localparam logic [15:0] CH_LOWER_U   = 16'h0075;

	// What the back part has to emit for one input word
	typedef enum logic [1:0] {
		KIND_PLAIN = 2'd0,  // the unit itself
		KIND_ESC   = 2'd1,  // backslash, then the character in unit
		KIND_UNI   = 2'd2,  // backslash, u, four hex digits
		KIND_END   = 2'd3   // closing quote, last set
	} jse_kind_t;

	typedef struct packed {
		logic        open;  // emit an opening quote first
		jse_kind_t   kind;
		logic [15:0] unit;
	} jse_cmd_t;

	// Queue head as seen by the back part
	typedef struct packed {
		logic     valid;
		jse_cmd_t cmd;
	} jse_head_t;

endpackage

/* design/jse_front.sv */
// ----------------------------------------------------------------------------
// JSON string escape encoder: front
// Accepts input words, tracks the open string and classifies each unit.
// ----------------------------------------------------------------------------
module jse_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [15:0]      code_unit,
	input  logic             end_of_string,
	input  logic             queue_full,
	output logic             in_ready,
	output logic             push,
	output jse_pkg::jse_cmd_t push_cmd
);
	import jse_pkg::*;

	logic string_open_q;

	assign in_ready = !queue_full;
	assign push     = in_valid && in_ready;

	always_comb begin
		push_cmd.open = !string_open_q;
		push_cmd.kind = KIND_PLAIN;
		push_cmd.unit = code_unit;
		if (end_of_string) begin
			push_cmd.kind = KIND_END;
			push_cmd.unit = CH_QUOTE;
		end else begin
			unique case (code_unit) inside
				CH_QUOTE, CH_BACKSLASH: begin
					push_cmd.kind = KIND_ESC;
				end
				16'h0008: begin
					push_cmd.kind = KIND_ESC;
					push_cmd.unit = 16'h0062;
				end
				16'h000C: begin
					push_cmd.kind = KIND_ESC;
					push_cmd.unit = 16'h0066;
				end
				16'h000A: begin
					push_cmd.kind = KIND_ESC;
					push_cmd.unit = 16'h006E;
				end
				16'h000D: begin
					push_cmd.kind = KIND_ESC;
					push_cmd.unit = 16'h0072;
				end
				16'h0009: begin
					push_cmd.kind = KIND_ESC;
					push_cmd.unit = 16'h0074;
				end
				default: begin
					if (code_unit < CH_SPACE || code_unit > CH_TILDE) begin
						push_cmd.kind = KIND_UNI;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			string_open_q <= 1'b0;
		end else if (push) begin
			string_open_q <= !end_of_string;
		end
	end

endmodule

/* design/jse_queue.sv */
// ----------------------------------------------------------------------------
// JSON string escape encoder: command queue
// Short register-based queue between the front and the back.
// ----------------------------------------------------------------------------
module jse_queue #(
	parameter int DEPTH = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  jse_pkg::jse_cmd_t push_cmd,
	input  logic              pop,
	output logic              full,
	output jse_pkg::jse_head_t head
);
	import jse_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	jse_cmd_t        regs_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	function automatic logic [AW-1:0] next_ptr(input logic [AW-1:0] p);
		next_ptr = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
	endfunction

	assign full       = (count_q == CW'(DEPTH));
	assign head.valid = (count_q != '0);
	assign head.cmd   = regs_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			regs_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

/* design/jse_back.sv */
// ----------------------------------------------------------------------------
// JSON string escape encoder: back
// Walks the queue head into the output register, one character per unstalled cycle.
// ----------------------------------------------------------------------------
module jse_back (
	input  logic               clk,
	input  logic               arst_n,
	input  jse_pkg::jse_head_t head,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [15:0]        out_char,
	output logic               last
);
	import jse_pkg::*;

	logic [2:0]  step_q;
	logic        out_valid_q;
	logic [15:0] out_char_q;
	logic        last_q;

	logic [2:0]  body_len;
	logic [2:0]  total;
	logic [2:0]  pos;
	logic        load;
	logic        final_step;
	logic [15:0] ch;
	logic        ch_last;

	function automatic logic [15:0] hex_char(input logic [3:0] d);
		hex_char = (d < 4'd10) ? (16'h0030 + {12'd0, d}) : (16'h0037 + {12'd0, d});
	endfunction

	always_comb begin
		case (head.cmd.kind)
			KIND_ESC: body_len = 3'd2;
			KIND_UNI: body_len = 3'd6;
			default:  body_len = 3'd1;
		endcase
		total      = body_len + {2'd0, head.cmd.open};
		pos        = step_q - {2'd0, head.cmd.open};
		final_step = (step_q == total - 3'd1);
		load       = head.valid && (!out_valid_q || out_ready);
		pop        = load && final_step;

		ch      = head.cmd.unit;
		ch_last = 1'b0;
		if (head.cmd.open && step_q == 3'd0) begin
			ch = CH_QUOTE;
		end else begin
			unique case (head.cmd.kind)
				KIND_END: begin
					ch_last = 1'b1;
				end
				KIND_ESC: begin
					if (pos == 3'd0) begin
						ch = CH_BACKSLASH;
					end
				end
				KIND_UNI: begin
					case (pos)
						3'd0:    ch = CH_BACKSLASH;
						3'd1:    ch = CH_LOWER_U;
						3'd2:    ch = hex_char(head.cmd.unit[15:12]);
						3'd3:    ch = hex_char(head.cmd.unit[11:8]);
						3'd4:    ch = hex_char(head.cmd.unit[7:4]);
						default: ch = hex_char(head.cmd.unit[3:0]);
					endcase
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_char_q <= ch;
			last_q     <= ch_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				step_q      <= final_step ? 3'd0 : step_q + 3'd1;
			end else if (out_ready) begin
				// drop the word once taken
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign last      = last_q;

endmodule

/* design/json_string_escape_encoder.sv */
// ----------------------------------------------------------------------------
// JSON string escape encoder
// Turns a stream of UTF-16 code units into escaped, quoted JSON string text.
// ----------------------------------------------------------------------------
// An input word is taken whenever the command queue (QUEUE_DEPTH entries)
// has room. The back part emits one output character per cycle while the
// queue holds a word and the output does not stall. A word produces 1 character
// for a printable unit or an end of string, 2 for a short escape, 6 for a
// \uXXXX escape, plus 1 when it opens a string. The input stalls only once
// the queue has filled behind escapes, opening quotes or a stalled output.
// Output passes a queue entry and then the output register before it is valid.
module json_string_escape_encoder #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] code_unit,
	input  logic        end_of_string,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] out_char,
	output logic        last
);
	import jse_pkg::*;

	logic      push;
	logic      pop;
	logic      queue_full;
	jse_cmd_t  push_cmd;
	jse_head_t head;

	jse_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.code_unit    (code_unit),
		.end_of_string(end_of_string),
		.queue_full   (queue_full),
		.in_ready     (in_ready),
		.push         (push),
		.push_cmd     (push_cmd)
	);

	jse_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_cmd(push_cmd),
		.pop     (pop),
		.full    (queue_full),
		.head    (head)
	);

	jse_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.pop      (pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_char (out_char),
		.last     (last)
	);

	// Every escaped character is printable ASCII
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_char >= CH_SPACE && out_char <= CH_TILDE))
		else $error("output character outside printable range");

	// The word that ends a string is always the closing quote
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && last) |-> (out_char == CH_QUOTE))
		else $error("last set on a character other than a quote");

	// The queue only pops an entry that is present
	assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head.valid)
		else $error("queue popped while empty");

endmodule
